FILE: src/seqc_pkg.sv
package seqc_pkg;

   localparam int DEF_WINDOW_RUNS = 4;
   localparam int WORDS_PER_RUN   = 8;
   localparam int WORD_BITS       = 64;
   localparam int RUN_BITS        = WORDS_PER_RUN * WORD_BITS;
   localparam int WORD_SEL_BITS   = 3;
   localparam int BIT_SEL_BITS    = 6;
   localparam int RUN_OFF_BITS    = WORD_SEL_BITS + BIT_SEL_BITS;

   localparam logic [63:0] SEQ_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] BASE_LIMIT = SEQ_MAX - 64'(RUN_BITS);

   localparam logic [1:0] MODE_MARK  = 2'd0;
   localparam logic [1:0] MODE_BELOW = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BELOW = 2'd1;
   localparam logic [1:0] ST_DROP  = 2'd2;

endpackage

FILE: src/seqc_ram.sv
module seqc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: src/sequence_completion_tracker.sv
// Sequence completion tracker.
// Input channel req_*: req_mode selects mark one number, mark every number
// below req_seq_number, or query. One transfer on rsp_* answers every request
// with the lowest incomplete number and a status (accepted, below base, or
// dropped beyond the window).
// Requests are handled one at a time; req_stall is high from acceptance until
// the response transfer completes. All bitmap words live in one single-port-
// write RAM, and every RAM access is a read or write of one 64-bit word.
// Steps per request: decode; then either the mark of one number, or the run
// advances and the fill of a mark-below; then full-run checks, each full run
// advanced; then the lowest-incomplete scan, by words and then by bytes; then
// the response.
// Reset: synchronous; afterwards the RAM is cleared one word a cycle, all
// WINDOW_RUNS*8 words, with req_stall high. A mark-up-to beyond the window
// clears the RAM again the same way.
// A stalled response holds its value; no new request is taken until it leaves.
module sequence_completion_tracker #(
   parameter int WINDOW_RUNS = seqc_pkg::DEF_WINDOW_RUNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_seq_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_lowest_incomplete,
   output logic [1:0]  rsp_status
);

   localparam int SW    = (WINDOW_RUNS > 1) ? $clog2(WINDOW_RUNS) : 1;
   localparam int CW    = $clog2(WINDOW_RUNS + 1);
   localparam int DEPTH = WINDOW_RUNS * seqc_pkg::WORDS_PER_RUN;
   localparam int AW    = $clog2(DEPTH);
   localparam int WSB   = seqc_pkg::WORD_SEL_BITS;
   localparam int OB    = seqc_pkg::RUN_OFF_BITS;
   localparam logic [63:0] WINDOW_BITS = 64'(WINDOW_RUNS) * 64'(seqc_pkg::RUN_BITS);
   localparam logic [WSB-1:0] LAST_WORD = WSB'(seqc_pkg::WORDS_PER_RUN - 1);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_DECODE, S_M0_RD, S_M0_WR, S_ADV, S_WIPE,
      S_FILL, S_FILL_WR, S_CAS_START, S_CAS_RD, S_CAS_CHK,
      S_LOW_RD, S_LOW_CHK, S_LOW_BYTE, S_RESP
   } state_type;

   state_type       state_ff, state_in;
   logic [1:0]      mode_ff, mode_in;
   logic [63:0]     seq_ff, seq_in;
   logic [63:0]     base_ff, base_in;
   logic [SW-1:0]   head_ff, head_in;
   logic [1:0]      status_ff, status_in;
   logic [WSB-1:0]  word_ff, word_in;
   logic [SW-1:0]   runs_ff, runs_in;
   logic [CW-1:0]   casc_ff, casc_in;
   logic            adv_cas_ff, adv_cas_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   tgt_ff, tgt_in;
   logic [5:0]      bit_ff, bit_in;
   logic [63:0]     vbuf_ff, vbuf_in;
   logic [OB-1:0]   off_ff, off_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [63:0]     rsp_low_ff, rsp_low_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   logic            mem_we;
   logic [AW-1:0]   mem_waddr, mem_raddr;
   logic [63:0]     mem_wdata, mem_rdata;

   logic [63:0]     diff;
   logic [63:0]     idx;
   logic [SW:0]     slot_sum;
   logic [SW-1:0]   slot;
   logic [SW-1:0]   head_next;
   logic [64:0]     low_sum;
   logic [WSB-1:0]  fill_full;
   logic [5:0]      fill_rem;

   function automatic logic [3:0] trail_ones(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 0; i < 8; i++) begin
         run = run & b[i];
         n   = n + 4'(run);
      end
      return n;
   endfunction

   seqc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign idx       = {seq_ff[63:OB], {OB{1'b0}}};
   assign diff      = ((mode_ff == seqc_pkg::MODE_BELOW) ? idx : seq_ff) - base_ff;
   assign slot_sum  = {1'b0, head_ff} + {1'b0, diff[OB +: SW]};
   assign slot      = (slot_sum >= (SW+1)'(WINDOW_RUNS)) ?
                      SW'(slot_sum - (SW+1)'(WINDOW_RUNS)) : SW'(slot_sum);
   assign head_next = ({1'b0, head_ff} + 1'b1 == (SW+1)'(WINDOW_RUNS)) ?
                      '0 : SW'({1'b0, head_ff} + 1'b1);
   assign fill_full = seq_ff[OB-1 -: WSB];
   assign fill_rem  = seq_ff[5:0];
   assign low_sum   = {1'b0, base_ff} + 65'(off_ff) + 65'(trail_ones(vbuf_ff[7:0]));

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      seq_in        = seq_ff;
      base_in       = base_ff;
      head_in       = head_ff;
      status_in     = status_ff;
      word_in       = word_ff;
      runs_in       = runs_ff;
      casc_in       = casc_ff;
      adv_cas_in    = adv_cas_ff;
      clr_in        = clr_ff;
      tgt_in        = tgt_ff;
      bit_in        = bit_ff;
      vbuf_in       = vbuf_ff;
      off_in        = off_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = AW'({head_ff, word_ff});
      mem_wdata     = '0;
      mem_raddr     = AW'({head_ff, word_ff});

      case (state_ff)
         S_INIT, S_WIPE: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               clr_in = '0;
               if (state_ff == S_INIT) begin
                  state_in = S_IDLE;
               end else begin
                  head_in  = '0;
                  base_in  = idx;
                  word_in  = '0;
                  state_in = S_FILL;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               seq_in   = req_seq_number;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = seqc_pkg::ST_OK;
            word_in   = '0;
            casc_in   = '0;
            case (mode_ff)
               seqc_pkg::MODE_MARK: begin
                  if (seq_ff < base_ff) begin
                     status_in = seqc_pkg::ST_BELOW;
                     state_in  = S_LOW_RD;
                  end else if (diff >= WINDOW_BITS) begin
                     status_in = seqc_pkg::ST_DROP;
                     state_in  = S_LOW_RD;
                  end else begin
                     tgt_in   = AW'({slot, diff[OB-1 -: WSB]});
                     bit_in   = diff[5:0];
                     state_in = S_M0_RD;
                  end
               end
               seqc_pkg::MODE_BELOW: begin
                  if (idx < base_ff) begin
                     status_in = seqc_pkg::ST_BELOW;
                     state_in  = S_LOW_RD;
                  end else if (diff >= WINDOW_BITS) begin
                     clr_in   = '0;
                     state_in = S_WIPE;
                  end else if (diff[OB +: SW] == '0) begin
                     state_in = S_FILL;
                  end else begin
                     runs_in    = diff[OB +: SW];
                     adv_cas_in = 1'b0;
                     state_in   = S_ADV;
                  end
               end
               default: begin
                  state_in = S_LOW_RD;
               end
            endcase
         end
         S_M0_RD: begin
            mem_raddr = tgt_ff;
            state_in  = S_M0_WR;
         end
         S_M0_WR: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = mem_rdata | (64'd1 << bit_ff);
            state_in  = S_CAS_START;
         end
         S_ADV: begin
            mem_we  = 1'b1;
            word_in = word_ff + 1'b1;
            if (word_ff == LAST_WORD) begin
               word_in = '0;
               head_in = head_next;
               base_in = base_ff + 64'(seqc_pkg::RUN_BITS);
               if (adv_cas_ff) begin
                  casc_in  = casc_ff + 1'b1;
                  state_in = S_CAS_START;
               end else begin
                  runs_in = runs_ff - 1'b1;
                  if (runs_ff == SW'(1)) begin
                     state_in = S_FILL;
                  end
               end
            end
         end
         S_FILL: begin
            if (word_ff < fill_full) begin
               mem_we    = 1'b1;
               mem_wdata = seqc_pkg::SEQ_MAX;
               word_in   = word_ff + 1'b1;
            end else if (fill_rem != '0) begin
               state_in = S_FILL_WR;
            end else begin
               state_in = S_CAS_START;
            end
         end
         S_FILL_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | ((64'd1 << fill_rem) - 64'd1);
            state_in  = S_CAS_START;
         end
         S_CAS_START: begin
            word_in = '0;
            if (casc_ff == CW'(WINDOW_RUNS) || base_ff > seqc_pkg::BASE_LIMIT) begin
               state_in = S_LOW_RD;
            end else begin
               state_in = S_CAS_RD;
            end
         end
         S_CAS_RD: begin
            state_in = S_CAS_CHK;
         end
         S_CAS_CHK: begin
            if (mem_rdata != seqc_pkg::SEQ_MAX) begin
               word_in  = '0;
               state_in = S_LOW_RD;
            end else if (word_ff == LAST_WORD) begin
               word_in    = '0;
               adv_cas_in = 1'b1;
               state_in   = S_ADV;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_CAS_RD;
            end
         end
         S_LOW_RD: begin
            state_in = S_LOW_CHK;
         end
         S_LOW_CHK: begin
            if (mem_rdata != seqc_pkg::SEQ_MAX) begin
               vbuf_in  = mem_rdata;
               off_in   = {word_ff, 6'd0};
               state_in = S_LOW_BYTE;
            end else if (word_ff == LAST_WORD) begin
               rsp_low_in    = seqc_pkg::SEQ_MAX;
               rsp_status_in = status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_LOW_RD;
            end
         end
         S_LOW_BYTE: begin
            if (vbuf_ff[7:0] == 8'hFF) begin
               vbuf_in = vbuf_ff >> 8;
               off_in  = off_ff + OB'(8);
            end else begin
               rsp_low_in    = low_sum[64] ? seqc_pkg::SEQ_MAX : low_sum[63:0];
               rsp_status_in = status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               word_in      = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (state_ff == S_FILL_WR || state_ff == S_FILL) begin
         mem_raddr = AW'({head_ff, fill_full});
         if (state_ff == S_FILL_WR) begin
            mem_waddr = AW'({head_ff, fill_full});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         base_ff      <= '0;
         head_ff      <= '0;
         word_ff      <= '0;
         runs_ff      <= '0;
         casc_ff      <= '0;
         adv_cas_ff   <= 1'b0;
         clr_ff       <= '0;
         status_ff    <= seqc_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         head_ff      <= head_in;
         word_ff      <= word_in;
         runs_ff      <= runs_in;
         casc_ff      <= casc_in;
         adv_cas_ff   <= adv_cas_in;
         clr_ff       <= clr_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      seq_ff        <= seq_in;
      tgt_ff        <= tgt_in;
      bit_ff        <= bit_in;
      vbuf_ff       <= vbuf_in;
      off_ff        <= off_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall             = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_lowest_incomplete = rsp_low_ff;
   assign rsp_status            = rsp_status_ff;

endmodule

FILE: src/seqc_checker.sv
module seqc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_lowest_incomplete,
   input logic [1:0]  rsp_status
);

   // one request in flight: no new transfer while a response waits
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == seqc_pkg::ST_OK || rsp_status == seqc_pkg::ST_BELOW ||
                     rsp_status == seqc_pkg::ST_DROP))
      else $error("bad status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_lowest_incomplete) &&
                                 $stable(rsp_status))
      else $error("stalled response changed");

   a_no_rsp_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response in the cycle after a request transfer");

endmodule

bind sequence_completion_tracker seqc_checker u_seqc_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

class completion_scoreboard;
   logic [63:0] base;
   logic [63:0] words[32];
   int unsigned head;
   logic [63:0] exp_lowest[$];
   logic [1:0]  exp_status[$];
   int          errors;

   function new();
      errors = 0;
      clear_all();
   endfunction

   function void clear_all();
      base = 0;
      head = 0;
      foreach (words[i]) words[i] = 0;
   endfunction

   function int slot(int unsigned ahead);
      return ((head + ahead) % 4) * 8;
   endfunction

   function bit run_full();
      int s;
      s = slot(0);
      for (int i = 0; i < 8; i++) if (words[s + i] != '1) return 0;
      return 1;
   endfunction

   function void advance();
      int s;
      s = slot(0);
      for (int i = 0; i < 8; i++) words[s + i] = 0;
      head = (head + 1) % 4;
      base = base + 512;
   endfunction

   function void cascade();
      for (int k = 0; k < 4; k++) begin
         if (!run_full()) break;
         if (base > seqc_pkg::BASE_LIMIT) break;
         advance();
      end
   endfunction

   function logic [63:0] lowest();
      int s;
      logic [63:0] v;
      logic [63:0] off;
      s = slot(0);
      for (int i = 0; i < 8; i++) begin
         v = words[s + i];
         if (v != '1) begin
            off = 64'(i) * 64;
            while (v[0]) begin
               off++;
               v = v >> 1;
            end
            if (off > seqc_pkg::SEQ_MAX - base) return seqc_pkg::SEQ_MAX;
            return base + off;
         end
      end
      return seqc_pkg::SEQ_MAX;
   endfunction

   function void note_request(logic [1:0] mode, logic [63:0] seq);
      logic [1:0]  st;
      logic [63:0] d;
      logic [63:0] idx;
      logic [63:0] runs;
      logic [63:0] n;
      int          s;
      st = seqc_pkg::ST_OK;
      if (mode == seqc_pkg::MODE_MARK) begin
         if (seq < base) st = seqc_pkg::ST_BELOW;
         else begin
            d = seq - base;
            if (d >= 2048) st = seqc_pkg::ST_DROP;
            else begin
               s = slot(d / 512);
               words[s + d[8:6]][d[5:0]] = 1'b1;
               cascade();
            end
         end
      end else if (mode == seqc_pkg::MODE_BELOW) begin
         idx = {seq[63:9], 9'd0};
         if (idx < base) st = seqc_pkg::ST_BELOW;
         else begin
            runs = (idx - base) / 512;
            if (runs >= 4) begin
               clear_all();
               base = idx;
            end else
               for (int k = 0; k < runs; k++) advance();
            s = slot(0);
            n = seq - idx;
            for (int i = 0; i < n / 64; i++) words[s + i] = '1;
            if (n[5:0] != 0)
               words[s + n / 64] = words[s + n / 64] | ((64'd1 << n[5:0]) - 1);
            cascade();
         end
      end
      exp_lowest.push_back(lowest());
      exp_status.push_back(st);
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   task check_response(logic [63:0] low, logic [1:0] st);
      logic [63:0] el;
      logic [1:0]  es;
      if (exp_lowest.size() == 0) begin
         report("unexpected transfer", low, 0);
         return;
      end
      el = exp_lowest.pop_front();
      es = exp_status.pop_front();
      if (low !== el) report("lowest_incomplete", low, el);
      if (st !== es) report("status", 64'(st), 64'(es));
   endtask
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_mode = seqc_pkg::MODE_MARK;
   logic [63:0] req_seq_number = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_lowest_incomplete;
   logic [1:0]  rsp_status;

   completion_scoreboard sb = new();
   int  cycles = 0;
   int  hold_off = 0;
   bit  calm = 0;
   bit  done = 0;
   logic [63:0] cursor = 0;

   sequence_completion_tracker dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("tb: failure");
         $finish;
      end
      if (!reset && req_valid && !req_stall) sb.note_request(req_mode, req_seq_number);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_lowest_incomplete, rsp_status);
   end

   // receiver: random stalls, one long hold-off
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else
         rsp_stall <= !calm && ($urandom_range(99) < 18);
   end

   task automatic send(logic [1:0] mode, logic [63:0] seq);
      while (!calm && $urandom_range(99) < 18) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_seq_number <= seq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] near_seq();
      logic [63:0] base;
      base = {cursor[63:9], 9'd0};
      case ($urandom_range(19))
         0: return base - 64'($urandom_range(1000));
         1: return base + 64'($urandom_range(2047)) + 2048;
         2: return {$urandom, $urandom};
         default: return base + 64'($urandom_range(1023));
      endcase
   endfunction

   initial begin
      logic [63:0] s;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send(seqc_pkg::MODE_QUERY, 0);
      send(seqc_pkg::MODE_MARK, 0);
      send(seqc_pkg::MODE_MARK, 1);
      send(seqc_pkg::MODE_MARK, 2047);
      send(seqc_pkg::MODE_MARK, 2048);
      send(seqc_pkg::MODE_BELOW, 511);
      send(seqc_pkg::MODE_MARK, 511);
      send(seqc_pkg::MODE_MARK, 0);
      send(seqc_pkg::MODE_BELOW, 1536 + 70);
      send(seqc_pkg::MODE_BELOW, 5000);
      send(seqc_pkg::MODE_SPARE, '1);
      send(seqc_pkg::MODE_BELOW, 1024 + 64);
      cursor = 64'd4608;
      send(seqc_pkg::MODE_BELOW, 0);
      fork
         begin
            repeat (20) @(negedge clock);
            hold_off = 400;
         end
         repeat (30) send(seqc_pkg::MODE_MARK, {$urandom, $urandom});
      join
      for (int i = 0; i < 1000; i++) begin
         calm = (i >= 400 && i < 550);
         case ($urandom_range(19))
            0, 1: send(($urandom_range(1) == 0) ? seqc_pkg::MODE_QUERY :
                       seqc_pkg::MODE_SPARE, {$urandom, $urandom});
            2: begin
               s = near_seq();
               send(seqc_pkg::MODE_BELOW, s);
               if ($urandom_range(3) == 0) cursor = s;
            end
            3: begin
               cursor = cursor + 512;
               send(seqc_pkg::MODE_BELOW, cursor + 64'($urandom_range(511)));
            end
            default: begin
               s = near_seq();
               send(seqc_pkg::MODE_MARK, s);
               if ($urandom_range(30) == 0) cursor = cursor + 512;
            end
         endcase
      end
      send(seqc_pkg::MODE_BELOW, 64'hFFFF_FFFF_FFFF_FE00);
      send(seqc_pkg::MODE_MARK, 64'hFFFF_FFFF_FFFF_FDFF);
      send(seqc_pkg::MODE_BELOW, '1);
      send(seqc_pkg::MODE_MARK, 64'hFFFF_FFFF_FFFF_FFFE);
      send(seqc_pkg::MODE_BELOW, 64'hFFFF_FFFF_FFFF_FC00);
      send(seqc_pkg::MODE_BELOW, 64'hAAAA_5555_AAAA_5555);
      send(seqc_pkg::MODE_MARK, 64'hAAAA_5555_AAAA_5555);
      req_valid <= 0;
      calm = 0;
      while (sb.exp_lowest.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

FILE: filelist.f
src/seqc_pkg.sv
src/seqc_ram.sv
src/sequence_completion_tracker.sv
src/seqc_checker.sv
tb/tb_top.sv
